// ===== sv/smj_pkg.sv =====
package smj_pkg;
    localparam int unsigned ProbeDepth = 1024;
    localparam int unsigned BuildDepth = 1024;
    localparam int unsigned PAW = (ProbeDepth > 1) ? $clog2(ProbeDepth) : 1;
    localparam int unsigned BAW = (BuildDepth > 1) ? $clog2(BuildDepth) : 1;
    localparam int unsigned PCW = $clog2(ProbeDepth + 1);
    localparam int unsigned BCW = $clog2(BuildDepth + 1);
    localparam int unsigned KeyW = 64;
    localparam int unsigned CntW = 21;
    localparam int unsigned SizeW = 11;
    localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

    localparam logic [1:0] ModeProbe = 2'd0;
    localparam logic [1:0] ModeBuild = 2'd1;
    localparam logic [1:0] ModeRun   = 2'd2;

    typedef enum logic [1:0] {
        t_sel_load  = 2'd0,
        t_sel_sort  = 2'd1,
        t_sel_merge = 2'd2
    } t_asel;

    // controller -> datapath
    typedef struct packed {
        logic            load_a;
        logic            load_b;
        logic            run_init;
        logic            sort_outer;  // start insertion of element i
        logic            sort_read;   // issue read of A[j-1]
        logic            sort_shift;  // A[j] <= A[j-1], j--
        logic            sort_place;  // A[j] <= v, i++
        logic            mrg_init;    // rewind i for the merge
        logic            mrg_step;    // consume registered data
        logic            clear;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sort_done;   // i >= na
        logic j_zero;
        logic gt;          // A[j-1] > v
        logic mrg_done;    // no run open, and i >= na or j >= nb
    } t_sts;

    function automatic logic [SizeW-1:0] sat_size(input logic [31:0] v);
        return (v > 32'((1 << SizeW) - 1)) ? {SizeW{1'b1}} : v[SizeW-1:0];
    endfunction
endpackage

// ===== sv/smj_ram.sv =====
module smj_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/smj_dp.sv =====
module smj_dp import smj_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [KeyW-1:0]  i_key,
    input  logic             i_build_uniq,
    output t_sts             o_sts,
    output logic [CntW-1:0]  o_match_count,
    output logic [SizeW-1:0] o_probe_size,
    output logic [SizeW-1:0] o_build_size,
    output logic             o_overflow
);
    logic [PCW-1:0]  r_na, r_i, r_j;
    logic [BCW-1:0]  r_nb, r_jb;
    logic            r_drop;
    logic [KeyW-1:0] r_v;
    logic [CntW-1:0] r_total;
    logic [PCW-1:0]  r_ca;      // current A run length
    logic [BCW-1:0]  r_cb;      // current B run length
    logic [KeyW-1:0] r_rkey;    // key of the current run
    logic            r_inrun;
    logic            r_hold_b;  // B run already closed in unique mode

    logic            a_we;
    logic [PAW-1:0]  a_waddr, a_raddr;
    logic [KeyW-1:0] a_wdata, a_rdata, b_rdata;
    logic [BAW-1:0]  b_raddr;

    always_comb begin
        a_we    = 1'b0;
        a_waddr = r_na[PAW-1:0];
        a_wdata = i_key;
        a_raddr = r_i[PAW-1:0];
        if (i_cmd.load_a && r_na < PCW'(ProbeDepth)) begin
            a_we = 1'b1;
        end else if (i_cmd.sort_shift) begin
            a_we    = 1'b1;
            a_waddr = r_j[PAW-1:0];
            a_wdata = a_rdata;
        end else if (i_cmd.sort_place) begin
            a_we    = 1'b1;
            a_waddr = r_j[PAW-1:0];
            a_wdata = r_v;
        end
        if (i_cmd.sort_read) begin
            a_raddr = PAW'(r_j - PCW'(1));
        end
        b_raddr = r_jb[BAW-1:0];
    end

    smj_ram #(.WIDTH(KeyW), .DEPTH(ProbeDepth)) u_ram_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );
    smj_ram #(.WIDTH(KeyW), .DEPTH(BuildDepth)) u_ram_b (
        .i_clk(i_clk), .i_we(i_cmd.load_b && r_nb < BCW'(BuildDepth)),
        .i_waddr(r_nb[BAW-1:0]), .i_wdata(i_key),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    // merge: a run is open once A and B keys meet; it extends while either
    // side still shows the run key (B only outside unique mode), and closes into the total
    logic                 a_in, b_in;
    logic [PCW+BCW-1:0]   prod;
    logic [PCW+BCW:0]     sum;
    logic [CntW-1:0]      add_total;

    always_comb begin
        a_in = r_inrun && a_rdata == r_rkey && r_i < r_na;
        b_in = r_inrun && !r_hold_b && b_rdata == r_rkey && r_jb < r_nb;
        prod = (PCW+BCW)'(r_ca) * (PCW+BCW)'(r_cb);
        sum  = (PCW+BCW+1)'(r_total) + (PCW+BCW+1)'(prod);
        add_total = (sum > (PCW+BCW+1)'(CountMax)) ? CountMax : sum[CntW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_na   <= '0;
            r_nb   <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.clear) begin
            r_na   <= '0;
            r_nb   <= '0;
            r_drop <= 1'b0;
        end else begin
            if (i_cmd.load_a) begin
                if (r_na < PCW'(ProbeDepth)) r_na <= r_na + PCW'(1);
                else r_drop <= 1'b1;
            end
            if (i_cmd.load_b) begin
                if (r_nb < BCW'(BuildDepth)) r_nb <= r_nb + BCW'(1);
                else r_drop <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_i      <= PCW'(1);
            r_total  <= '0;
            r_inrun  <= 1'b0;
            r_jb     <= '0;
        end
        if (i_cmd.sort_outer) begin
            r_j <= r_i;
        end
        if (i_cmd.sort_read) begin
            if (r_j == r_i) r_v <= a_rdata;  // A[i] read by the outer step
        end
        if (i_cmd.sort_shift) begin
            r_j <= r_j - PCW'(1);
        end
        if (i_cmd.sort_place) begin
            r_i <= r_i + PCW'(1);
        end
        if (i_cmd.mrg_init) begin
            r_i <= '0;
        end
        if (i_cmd.mrg_step) begin
            if (r_inrun) begin
                if (a_in) begin
                    r_ca <= r_ca + PCW'(1);
                    r_i  <= r_i + PCW'(1);
                end else if (b_in) begin
                    r_cb <= r_cb + BCW'(1);
                    r_jb <= r_jb + BCW'(1);
                end else begin
                    r_total <= add_total;
                    r_inrun <= 1'b0;
                end
            end else if (a_rdata < b_rdata) begin
                r_i <= r_i + PCW'(1);
            end else if (a_rdata > b_rdata) begin
                r_jb <= r_jb + BCW'(1);
            end else begin
                r_inrun  <= 1'b1;
                r_rkey   <= a_rdata;
                r_ca     <= PCW'(1);
                r_cb     <= BCW'(1);
                r_hold_b <= i_build_uniq;
                r_i      <= r_i + PCW'(1);
                r_jb     <= r_jb + BCW'(1);
            end
        end
    end

    always_comb begin
        o_sts.sort_done = r_i >= r_na;
        o_sts.j_zero    = r_j == '0;
        o_sts.gt        = a_rdata > r_v;
        o_sts.mrg_done  = !r_inrun && (r_i >= r_na || r_jb >= r_nb);
        o_match_count   = r_total;
        o_probe_size    = sat_size(32'(r_na));
        o_build_size    = sat_size(32'(r_nb));
        o_overflow      = r_drop;
    end

    a_na_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_na <= PCW'(ProbeDepth)) else $error("probe count past depth");
    a_nb_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nb <= BCW'(BuildDepth)) else $error("build count past depth");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_na == '0 && r_nb == '0 && !r_drop))
        else $error("tables not emptied");
endmodule

// ===== sv/smj_ctrl.sv =====
module smj_ctrl import smj_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_out_load,
    input  logic       i_out_free
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_SOUTER = 8'b00000010,
        S_SWAIT  = 8'b00000100,
        S_SCMP   = 8'b00001000,
        S_MINIT  = 8'b00010000,
        S_MREAD  = 8'b00100000,
        S_MSTEP  = 8'b01000000,
        S_DONE   = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_ready    = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_mode)
                        ModeProbe: o_cmd.load_a = 1'b1;
                        ModeBuild: o_cmd.load_b = 1'b1;
                        ModeRun: begin
                            o_cmd.run_init = 1'b1;
                            n_state = S_SOUTER;
                        end
                        default: ;
                    endcase
                end
            end
            S_SOUTER: begin
                // read A[i] to hold as the value being inserted
                if (i_sts.sort_done) begin
                    n_state = S_MINIT;
                end else begin
                    o_cmd.sort_outer = 1'b1;
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: begin
                o_cmd.sort_read = 1'b1;  // latches A[i] as v when j == i, reads A[j-1]
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (!i_sts.j_zero && i_sts.gt) begin
                    o_cmd.sort_shift = 1'b1;
                    n_state = S_SWAIT;
                end else begin
                    o_cmd.sort_place = 1'b1;
                    n_state = S_SOUTER;
                end
            end
            S_MINIT: begin
                o_cmd.mrg_init = 1'b1;
                n_state = S_MREAD;
            end
            S_MREAD: begin
                if (i_sts.mrg_done) n_state = S_DONE;
                else n_state = S_MSTEP;
            end
            S_MSTEP: begin
                o_cmd.mrg_step = 1'b1;
                n_state = S_MREAD;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |=> r_state == S_IDLE) else $error("result not closing run");
endmodule

// ===== sv/sort_merge_join_count.sv =====
// Equi-join match counter.
// Input channel (i_valid/o_ready) takes words with i_mode and i_key:
// mode 0 appends a probe key, mode 1 a build key, mode 2 runs the join,
// mode 3 is dropped. Loads are accepted one per cycle while idle and give
// no result; keys past a table's depth are dropped and flag overflow.
// A run insertion-sorts the probe RAM in place, reading each element and
// shifting each larger entry below it up one place until it is placed,
// rewinds, then merges both tables in steps that each wait for the
// registered RAM read and then move a pointer or close a run. Input is
// not ready during a run. When the merge ends and the output register is
// free, the result word (o_valid/i_ready) is loaded with match count, both
// sizes and overflow, and both tables are emptied.
// The result sits in an output register; if the receiver stalls it holds,
// and the next word is still accepted, with a further run waiting until
// the register is free.
// Configuration (i_cfg_valid/o_cfg_ready) writes the unique-build flag;
// always ready.
// Synchronous reset empties both tables, clears overflow, sets the flag.
// RAM contents are not cleared; only written entries are read.
module sort_merge_join_count import smj_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_mode,
    input  logic [KeyW-1:0]  i_key,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CntW-1:0]  o_match_count,
    output logic [SizeW-1:0] o_probe_size,
    output logic [SizeW-1:0] o_build_size,
    output logic             o_overflow,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data
);
    t_cmd             cmd;
    t_sts             sts;
    logic             out_load;
    logic [CntW-1:0]  dp_count;
    logic [SizeW-1:0] dp_psize, dp_bsize;
    logic             dp_ovf;
    logic             r_build_uniq;
    logic             r_valid;
    logic [CntW-1:0]  r_count;
    logic [SizeW-1:0] r_psize, r_bsize;
    logic             r_ovf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_build_uniq <= 1'b1;
        end else if (i_cfg_valid) begin
            r_build_uniq <= i_cfg_data;
        end
    end

    smj_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_sts(sts), .o_cmd(cmd), .o_out_load(out_load),
        .i_out_free(!r_valid || i_ready)
    );

    smj_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_key(i_key),
        .i_build_uniq(r_build_uniq), .o_sts(sts), .o_match_count(dp_count),
        .o_probe_size(dp_psize), .o_build_size(dp_bsize), .o_overflow(dp_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_count <= dp_count;
            r_psize <= dp_psize;
            r_bsize <= dp_bsize;
            r_ovf   <= dp_ovf;
        end
    end

    assign o_valid       = r_valid;
    assign o_match_count = r_count;
    assign o_probe_size  = r_psize;
    assign o_build_size  = r_bsize;
    assign o_overflow    = r_ovf;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_count)))
        else $error("stalled result changed");
    a_noload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_valid || i_ready)) else $error("result overwritten");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid && i_mode == ModeRun) |=> !o_ready)
        else $error("run not blocking input");
endmodule
